>>> src/peak_preserving_decimator_macros.svh
// assertion macros shared by the decimator modules
`ifndef PEAK_PRESERVING_DECIMATOR_MACROS_SVH
`define PEAK_PRESERVING_DECIMATOR_MACROS_SVH

// condition holds in the same cycle as the trigger
`define PPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ppd_pkg.sv
package ppd_pkg;

	// field widths
	localparam int CHANNEL_W = 9;
	localparam int SAMPLE_W = 16;
	localparam int FACTOR_W = 13;
	localparam int CHCOUNT_W = 10;
	localparam int BIN_COUNT_W = 12;
	localparam int MAX_CHANNELS = 2 ** CHANNEL_W;

	// factor limits
	localparam logic [FACTOR_W-1:0] FACTOR_MIN = FACTOR_W'(1);
	localparam logic [FACTOR_W-1:0] FACTOR_MAX = FACTOR_W'(4096);

	// register map
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_DOWN_FACTOR = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPIKE_COUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_NEURAL_COUNT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MIX_LOW_BAND = 2'd3;

	// queue sizes
	localparam int ITEM_QUEUE_DEPTH = 4;
	localparam int ITEM_PTR_W = $clog2(ITEM_QUEUE_DEPTH);
	localparam int ITEM_CNT_W = $clog2(ITEM_QUEUE_DEPTH + 1);
	localparam int RESULT_QUEUE_DEPTH = 4;
	localparam int RESULT_PTR_W = $clog2(RESULT_QUEUE_DEPTH);
	localparam int RESULT_CNT_W = $clog2(RESULT_QUEUE_DEPTH + 1);

	// live configuration, factor already clamped
	typedef struct packed {
		logic [FACTOR_W-1:0] factor;
		logic [CHCOUNT_W-1:0] spike_count;
		logic [CHCOUNT_W-1:0] neural_count;
		logic mix;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic signed [SAMPLE_W-1:0] value;
		logic last;
		logic peak;
	} item_t;

	// per-channel bin state
	typedef struct packed {
		logic [BIN_COUNT_W-1:0] count;
		logic signed [SAMPLE_W-1:0] low;
		logic signed [SAMPLE_W-1:0] high;
	} entry_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic signed [SAMPLE_W-1:0] value;
	} result_t;

endpackage

>>> src/ppd_front.sv
`include "peak_preserving_decimator_macros.svh"

module ppd_front (
	input  logic clk,
	input  logic arst_n,
	input  ppd_pkg::cfg_t cfg,
	input  logic clearing,
	input  logic push,
	output logic full,
	input  logic [ppd_pkg::CHANNEL_W-1:0] channel,
	input  logic signed [ppd_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [ppd_pkg::SAMPLE_W-1:0] paired_sample,
	input  logic chunk_end,
	output ppd_pkg::item_t head,
	output logic head_valid,
	input  logic head_pop
);

	ppd_pkg::item_t queue_q [ppd_pkg::ITEM_QUEUE_DEPTH];
	logic [ppd_pkg::ITEM_PTR_W-1:0] wr_ptr_q;
	logic [ppd_pkg::ITEM_PTR_W-1:0] rd_ptr_q;
	logic [ppd_pkg::ITEM_CNT_W-1:0] count_q;
	logic accept;
	logic spike;
	logic mix_on;
	logic signed [ppd_pkg::SAMPLE_W-1:0] mixed;
	ppd_pkg::item_t item;

	// classify the incoming sample
	always_comb begin
		spike = {1'b0, channel} < cfg.spike_count;
		mix_on = cfg.mix && ({1'b0, cfg.neural_count} == {cfg.spike_count, 1'b0});
		mixed = sample + paired_sample;
		item.channel = channel;
		item.value = (spike && mix_on) ? mixed : sample;
		item.last = chunk_end;
		item.peak = spike && (cfg.factor > ppd_pkg::FACTOR_MIN);
	end

	assign full = (count_q == ppd_pkg::ITEM_CNT_W'(ppd_pkg::ITEM_QUEUE_DEPTH)) || clearing;
	assign accept = push && !full;
	assign head_valid = (count_q != '0);
	assign head = queue_q[rd_ptr_q];

	// item queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	// item queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({accept, head_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`PPD_ASSERT_NOW(a_item_pop_nonempty, clk, arst_n, head_pop, head_valid, "pop from empty item queue")

endmodule

>>> src/ppd_back.sv
`include "peak_preserving_decimator_macros.svh"

module ppd_back (
	input  logic clk,
	input  logic arst_n,
	input  ppd_pkg::cfg_t cfg,
	output logic clearing,
	input  ppd_pkg::item_t head,
	input  logic head_valid,
	output logic head_pop,
	input  logic res_full,
	output logic res_push,
	output ppd_pkg::result_t res_data
);

	ppd_pkg::entry_t mem [ppd_pkg::MAX_CHANNELS];
	ppd_pkg::entry_t rdata_s1;
	ppd_pkg::item_t item_s1;
	logic valid_s1;
	logic adv;
	logic s1_wr;

	logic clr_busy_q;
	logic [ppd_pkg::CHANNEL_W-1:0] clr_idx_q;

	logic last_wr_valid_q;
	logic [ppd_pkg::CHANNEL_W-1:0] last_wr_ch_q;
	ppd_pkg::entry_t last_wr_q;

	ppd_pkg::entry_t cur;
	ppd_pkg::entry_t nxt;
	logic mem_we;
	logic [ppd_pkg::CHANNEL_W-1:0] mem_wa;
	ppd_pkg::entry_t mem_wd;
	logic emit;
	logic signed [ppd_pkg::SAMPLE_W-1:0] res_value;

	function automatic logic [ppd_pkg::SAMPLE_W:0] mag(input logic signed [ppd_pkg::SAMPLE_W-1:0] x);
		logic [ppd_pkg::SAMPLE_W:0] w;
		w = {x[ppd_pkg::SAMPLE_W-1], x};
		return x[ppd_pkg::SAMPLE_W-1] ? (~w + 1'b1) : w;
	endfunction

	assign clearing = clr_busy_q;
	assign adv = !res_full;
	assign head_pop = head_valid && adv && !clr_busy_q;
	assign s1_wr = valid_s1 && adv;

	// bin update for the item in stage 1
	always_comb begin
		logic signed [ppd_pkg::SAMPLE_W-1:0] v;
		logic signed [ppd_pkg::SAMPLE_W-1:0] lo;
		logic signed [ppd_pkg::SAMPLE_W-1:0] hi;
		logic [ppd_pkg::BIN_COUNT_W:0] cnt_inc;
		logic first;
		logic close;
		v = item_s1.value;
		cur = (last_wr_valid_q && (last_wr_ch_q == item_s1.channel)) ? last_wr_q : rdata_s1;
		first = (cur.count == '0);
		cnt_inc = {1'b0, cur.count} + 1'b1;
		close = (cnt_inc >= cfg.factor) || item_s1.last;
		lo = cur.low;
		hi = cur.high;
		nxt = cur;
		emit = 1'b0;
		res_value = v;
		if (item_s1.peak) begin
			if (first || (v < lo)) begin
				lo = v;
			end
			if (first || (v > hi)) begin
				hi = v;
			end
			nxt.low = lo;
			nxt.high = hi;
			if (close) begin
				emit = 1'b1;
				res_value = (mag(lo) > mag(hi)) ? lo : hi;
			end
		end else begin
			emit = first;
		end
		nxt.count = close ? '0 : cnt_inc[ppd_pkg::BIN_COUNT_W-1:0];
	end

	// memory write port: clearing sweep or bin update
	always_comb begin
		mem_we = clr_busy_q || s1_wr;
		mem_wa = clr_busy_q ? clr_idx_q : item_s1.channel;
		mem_wd = clr_busy_q ? '0 : nxt;
	end

	assign res_push = s1_wr && emit;
	assign res_data.channel = item_s1.channel;
	assign res_data.value = res_value;

	// bin state memory, read as the item enters stage 1
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (head_pop) begin
			rdata_s1 <= mem[head.channel];
		end
	end

	// stage 1 payload and last write for forwarding
	always_ff @(posedge clk) begin
		if (head_pop) begin
			item_s1 <= head;
		end
		if (s1_wr) begin
			last_wr_ch_q <= item_s1.channel;
			last_wr_q <= nxt;
		end
	end

	// stage control and clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_wr_valid_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			if (adv) begin
				valid_s1 <= head_pop;
			end
			if (s1_wr) begin
				last_wr_valid_q <= 1'b1;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == ppd_pkg::CHANNEL_W'(ppd_pkg::MAX_CHANNELS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	`PPD_ASSERT_NOW(a_no_pop_while_clearing, clk, arst_n, clr_busy_q, !head_pop && !valid_s1, "item taken during clearing sweep")
	`PPD_ASSERT_NOW(a_push_has_room, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`PPD_ASSERT_NEXT(a_forward_tracks_write, clk, arst_n, s1_wr, last_wr_valid_q && (last_wr_ch_q == $past(item_s1.channel)), "forwarding register missed a write")

endmodule

>>> src/ppd_result_queue.sv
`include "peak_preserving_decimator_macros.svh"

module ppd_result_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ppd_pkg::result_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output ppd_pkg::result_t head
);

	ppd_pkg::result_t queue_q [ppd_pkg::RESULT_QUEUE_DEPTH];
	logic [ppd_pkg::RESULT_PTR_W-1:0] wr_ptr_q;
	logic [ppd_pkg::RESULT_PTR_W-1:0] rd_ptr_q;
	logic [ppd_pkg::RESULT_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == ppd_pkg::RESULT_CNT_W'(ppd_pkg::RESULT_QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = queue_q[rd_ptr_q];

	// result storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`PPD_ASSERT_NOW(a_level_in_range, clk, arst_n, 1'b1, count_q <= ppd_pkg::RESULT_CNT_W'(ppd_pkg::RESULT_QUEUE_DEPTH), "result queue level overflow")

endmodule

>>> src/peak_preserving_decimator.sv
// peak preserving decimator
// input channel: push with channel, sample, paired_sample and chunk_end; a transfer
//   happens on a clock edge with push high and full low
// result channel: while empty is low the oldest result sits on out_channel and
//   out_value; a transfer happens on a clock edge with pop high and empty low
// configuration: apb write of down_factor, spike_channel_count, neural_channel_count
//   and mix_low_band at byte addresses 0, 4, 8, 12; pready is always high
// throughput: one sample per cycle sustained while the result queue is not full; the
//   per-channel bin state sits in a single memory with one read and one write port,
//   read as an item leaves the item queue and written as it leaves stage 1, with a
//   forwarding register covering back-to-back samples of the same channel
// path: a result reaches the result ports through the item queue, the stage 1
//   register and the result queue, and can be taken at the next edge
// reset: after arst_n rises the bin memory is swept to zero, during which full
//   stays high; configuration writes are taken at any time
// stall: when pop stays low the four-entry result queue fills, the back end holds,
//   the four-entry item queue fills and full rises; nothing is dropped

module peak_preserving_decimator (
	input  logic clk,
	input  logic arst_n,
	// configuration port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ppd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ppd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ppd_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	// input channel
	input  logic push,
	output logic full,
	input  logic [ppd_pkg::CHANNEL_W-1:0] channel,
	input  logic signed [ppd_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [ppd_pkg::SAMPLE_W-1:0] paired_sample,
	input  logic chunk_end,
	// result channel
	output logic empty,
	input  logic pop,
	output logic [ppd_pkg::CHANNEL_W-1:0] out_channel,
	output logic signed [ppd_pkg::SAMPLE_W-1:0] out_value
);

	logic [ppd_pkg::FACTOR_W-1:0] down_factor_q;
	logic [ppd_pkg::CHCOUNT_W-1:0] spike_count_q;
	logic [ppd_pkg::CHCOUNT_W-1:0] neural_count_q;
	logic mix_q;
	logic [ppd_pkg::REG_IDX_W-1:0] reg_idx;
	logic reg_wr;
	ppd_pkg::cfg_t cfg;
	logic clearing;
	ppd_pkg::item_t head;
	logic head_valid;
	logic head_pop;
	logic res_full;
	logic res_push;
	ppd_pkg::result_t res_data;
	ppd_pkg::result_t res_head;

	assign pready = 1'b1;
	assign reg_idx = paddr[ppd_pkg::REG_IDX_W+1:2];
	assign reg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_factor_q <= ppd_pkg::FACTOR_MIN;
			spike_count_q <= '0;
			neural_count_q <= '0;
			mix_q <= 1'b0;
		end else if (reg_wr) begin
			case (reg_idx)
				ppd_pkg::REG_DOWN_FACTOR: down_factor_q <= pwdata[ppd_pkg::FACTOR_W-1:0];
				ppd_pkg::REG_SPIKE_COUNT: spike_count_q <= pwdata[ppd_pkg::CHCOUNT_W-1:0];
				ppd_pkg::REG_NEURAL_COUNT: neural_count_q <= pwdata[ppd_pkg::CHCOUNT_W-1:0];
				ppd_pkg::REG_MIX_LOW_BAND: mix_q <= pwdata[0];
				default: mix_q <= mix_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			ppd_pkg::REG_DOWN_FACTOR: prdata = ppd_pkg::APB_DATA_W'(down_factor_q);
			ppd_pkg::REG_SPIKE_COUNT: prdata = ppd_pkg::APB_DATA_W'(spike_count_q);
			ppd_pkg::REG_NEURAL_COUNT: prdata = ppd_pkg::APB_DATA_W'(neural_count_q);
			ppd_pkg::REG_MIX_LOW_BAND: prdata = ppd_pkg::APB_DATA_W'(mix_q);
			default: prdata = '0;
		endcase
	end

	// clamp the factor to its working range
	always_comb begin
		if (down_factor_q == '0) begin
			cfg.factor = ppd_pkg::FACTOR_MIN;
		end else if (down_factor_q > ppd_pkg::FACTOR_MAX) begin
			cfg.factor = ppd_pkg::FACTOR_MAX;
		end else begin
			cfg.factor = down_factor_q;
		end
		cfg.spike_count = spike_count_q;
		cfg.neural_count = neural_count_q;
		cfg.mix = mix_q;
	end

	ppd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.clearing      (clearing),
		.push          (push),
		.full          (full),
		.channel       (channel),
		.sample        (sample),
		.paired_sample (paired_sample),
		.chunk_end     (chunk_end),
		.head          (head),
		.head_valid    (head_valid),
		.head_pop      (head_pop)
	);

	ppd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clearing   (clearing),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	ppd_result_queue u_result_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.full      (res_full),
		.pop       (pop),
		.empty     (empty),
		.head      (res_head)
	);

	assign out_channel = res_head.channel;
	assign out_value = res_head.value;

endmodule

>>> bench/peak_preserving_decimator_test.sv
module peak_preserving_decimator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 55;

	typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [ppd_pkg::REG_IDX_W-1:0] reg_idx;
		logic [ppd_pkg::APB_DATA_W-1:0] wdata;
		logic [ppd_pkg::CHANNEL_W-1:0] ch;
		logic signed [ppd_pkg::SAMPLE_W-1:0] smp;
		logic signed [ppd_pkg::SAMPLE_W-1:0] pair;
		bit last;
		bit typed;
		bit emit;
		logic signed [ppd_pkg::SAMPLE_W-1:0] value;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ppd_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [ppd_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [ppd_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [ppd_pkg::CHANNEL_W-1:0] channel = '0;
	logic signed [ppd_pkg::SAMPLE_W-1:0] sample = '0;
	logic signed [ppd_pkg::SAMPLE_W-1:0] paired_sample = '0;
	logic chunk_end = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic [ppd_pkg::CHANNEL_W-1:0] out_channel;
	logic signed [ppd_pkg::SAMPLE_W-1:0] out_value;

	// typed expectation travelling with the item on the bus
	bit row_typed = 1'b0;
	bit row_emit = 1'b0;
	logic signed [ppd_pkg::SAMPLE_W-1:0] row_value = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int unsigned cycle_count = 0;

	// predictor copy of registers and bin state
	logic [ppd_pkg::FACTOR_W-1:0] factor_reg = ppd_pkg::FACTOR_MIN;
	logic [ppd_pkg::CHCOUNT_W-1:0] spike_reg = '0;
	logic [ppd_pkg::CHCOUNT_W-1:0] neural_reg = '0;
	logic mix_reg = 1'b0;
	logic [ppd_pkg::BIN_COUNT_W-1:0] ch_count [ppd_pkg::MAX_CHANNELS];
	logic signed [ppd_pkg::SAMPLE_W-1:0] ch_low [ppd_pkg::MAX_CHANNELS];
	logic signed [ppd_pkg::SAMPLE_W-1:0] ch_high [ppd_pkg::MAX_CHANNELS];

	ppd_pkg::result_t pending_out [$];
	stim_row_t plan [$];

	peak_preserving_decimator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.channel(channel),
		.sample(sample),
		.paired_sample(paired_sample),
		.chunk_end(chunk_end),
		.empty(empty),
		.pop(pop),
		.out_channel(out_channel),
		.out_value(out_value)
	);

	always #5ns clk = ~clk;

	initial begin
		foreach (ch_count[i]) begin
			ch_count[i] = '0;
			ch_low[i] = '0;
			ch_high[i] = '0;
		end
	end

	// one sample through the per-channel bin
	function automatic void decimate_sample(input logic [ppd_pkg::CHANNEL_W-1:0] ch,
			input logic signed [ppd_pkg::SAMPLE_W-1:0] smp,
			input logic signed [ppd_pkg::SAMPLE_W-1:0] pair,
			input logic last, output bit hit, output ppd_pkg::result_t res);
		int f;
		int cnt;
		int mag_lo;
		int mag_hi;
		bit peak;
		logic signed [ppd_pkg::SAMPLE_W-1:0] v;
		f = (factor_reg == 0) ? 1 : ((factor_reg > 4096) ? 4096 : int'(factor_reg));
		peak = int'(ch) < int'(spike_reg);
		v = smp;
		if (peak && mix_reg && int'(neural_reg) == 2 * int'(spike_reg))
			v = smp + pair;
		cnt = ch_count[ch];
		hit = 1'b0;
		res.channel = ch;
		res.value = '0;
		if (peak && f > 1) begin
			if (cnt == 0) begin
				ch_low[ch] = v;
				ch_high[ch] = v;
			end else begin
				if (v < ch_low[ch]) ch_low[ch] = v;
				if (v > ch_high[ch]) ch_high[ch] = v;
			end
			cnt++;
			// close the bin on the larger magnitude, maximum wins ties
			if (cnt >= f || last) begin
				mag_lo = (ch_low[ch] < 0) ? -int'(ch_low[ch]) : int'(ch_low[ch]);
				mag_hi = (ch_high[ch] < 0) ? -int'(ch_high[ch]) : int'(ch_high[ch]);
				res.value = (mag_lo > mag_hi) ? ch_low[ch] : ch_high[ch];
				hit = 1'b1;
				cnt = 0;
			end
		end else begin
			// first sample of each bin passes
			if (cnt == 0) begin
				res.value = v;
				hit = 1'b1;
			end
			cnt++;
			if (cnt >= f || last) cnt = 0;
		end
		ch_count[ch] = cnt[ppd_pkg::BIN_COUNT_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("mismatch %s: expected %0d, got %0d", what, want, got);
		fail_count++;
	endtask

	// watch all three ports at the clock edge
	always @(posedge clk) begin
		bit hit;
		ppd_pkg::result_t res;
		ppd_pkg::result_t want;
		if (arst_n) begin
			// register transfer
			if (psel && penable && pwrite && pready) begin
				case (paddr[ppd_pkg::REG_IDX_W+1:2])
					ppd_pkg::REG_DOWN_FACTOR: factor_reg = pwdata[ppd_pkg::FACTOR_W-1:0];
					ppd_pkg::REG_SPIKE_COUNT: spike_reg = pwdata[ppd_pkg::CHCOUNT_W-1:0];
					ppd_pkg::REG_NEURAL_COUNT: neural_reg = pwdata[ppd_pkg::CHCOUNT_W-1:0];
					ppd_pkg::REG_MIX_LOW_BAND: mix_reg = pwdata[0];
					default: ;
				endcase
			end
			// result transfer
			if (pop && !empty) begin
				if (pending_out.size() == 0) begin
					report_mismatch("unexpected result, channel", -1, int'(out_channel));
				end else begin
					want = pending_out.pop_front();
					if (out_channel !== want.channel)
						report_mismatch("out_channel", int'(want.channel), int'(out_channel));
					if (out_value !== want.value)
						report_mismatch("out_value", int'(want.value), int'(out_value));
				end
			end
			// input transfer
			if (push && !full) begin
				decimate_sample(channel, sample, paired_sample, chunk_end, hit, res);
				if (row_typed) begin
					hit = row_emit;
					res.channel = channel;
					res.value = row_value;
				end
				if (hit) pending_out.push_back(res);
			end
		end
	end

	// receiver side
	always @(posedge clk) pop <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_item(input stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		channel <= row.ch;
		sample <= row.smp;
		paired_sample <= row.pair;
		chunk_end <= row.last;
		row_typed <= row.typed;
		row_emit <= row.emit;
		row_value <= row.value;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ppd_pkg::REG_IDX_W-1:0] idx,
			input logic [ppd_pkg::APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every pending result, then for work that gives none
	task automatic settle();
		push <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic stim_row_t reg_row(input logic [ppd_pkg::REG_IDX_W-1:0] idx,
			input int value);
		stim_row_t r;
		r = '{kind: ROW_REG, default: '0};
		r.reg_idx = idx;
		r.wdata = value;
		return r;
	endfunction

	function automatic stim_row_t item_row(input int ch, input int smp, input int pair,
			input bit last, input bit typed = 1'b0, input bit emit = 1'b0,
			input int value = 0);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		r.ch = ppd_pkg::CHANNEL_W'(ch);
		r.smp = ppd_pkg::SAMPLE_W'(smp);
		r.pair = ppd_pkg::SAMPLE_W'(pair);
		r.last = last;
		r.typed = typed;
		r.emit = emit;
		r.value = ppd_pkg::SAMPLE_W'(value);
		return r;
	endfunction

	function automatic stim_row_t random_item();
		int pick;
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		// most samples land on a few channels so bins close often
		r.ch = ppd_pkg::CHANNEL_W'(($urandom_range(99) < 70) ? $urandom_range(0, 7)
				: $urandom_range(0, 511));
		if ($urandom_range(99) < 10) begin
			pick = $urandom_range(3);
			case (pick)
				0: r.smp = 16'sh7fff;
				1: r.smp = 16'sh8000;
				2: r.smp = 16'sh0000;
				default: r.smp = 16'shffff;
			endcase
		end else begin
			r.smp = ppd_pkg::SAMPLE_W'($urandom());
		end
		r.pair = ppd_pkg::SAMPLE_W'($urandom());
		r.last = ($urandom_range(7) == 0);
		return r;
	endfunction

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("peak_preserving_decimator_test failed");
		$finish;
	end

	initial begin
		int fac;
		int spk;
		int neu;
		int mix;
		// reset values: every sample passes
		plan.push_back(item_row(0, 32767, 0, 0, 1, 1, 32767));
		plan.push_back(item_row(511, -32768, 0, 0, 1, 1, -32768));
		plan.push_back(item_row(5, 0, -1, 1, 1, 1, 0));
		plan.push_back(item_row(5, -1, 0, 0, 1, 1, -1));
		// zero factor behaves as one
		plan.push_back(reg_row(ppd_pkg::REG_DOWN_FACTOR, 0));
		plan.push_back(item_row(3, 16'h1234, 0, 0, 1, 1, 16'h1234));
		// peak binning by three on channels below four
		plan.push_back(reg_row(ppd_pkg::REG_SPIKE_COUNT, 4));
		plan.push_back(reg_row(ppd_pkg::REG_DOWN_FACTOR, 3));
		plan.push_back(item_row(1, 100, 0, 0, 1, 0));
		plan.push_back(item_row(1, -200, 0, 0, 1, 0));
		plan.push_back(item_row(1, 50, 0, 0, 1, 1, -200));
		// equal magnitudes give the maximum
		plan.push_back(item_row(2, -300, 0, 0, 1, 0));
		plan.push_back(item_row(2, 300, 0, 0, 1, 0));
		plan.push_back(item_row(2, 0, 0, 0, 1, 1, 300));
		// short bin flushed at chunk end
		plan.push_back(item_row(1, 7, 0, 1, 1, 1, 7));
		// plain channel keeps the first sample of its bin
		plan.push_back(item_row(10, 5, 0, 0, 1, 1, 5));
		plan.push_back(item_row(10, 6, 0, 0, 1, 0));
		plan.push_back(item_row(10, 7, 0, 0, 1, 0));
		// factor change with a bin still open
		plan.push_back(item_row(3, -5, 0, 0));
		plan.push_back(reg_row(ppd_pkg::REG_DOWN_FACTOR, 1));
		plan.push_back(item_row(3, 9, 0, 0));
		plan.push_back(item_row(3, 11, 0, 0));
		// low-band mixing wraps at 16 bits
		plan.push_back(reg_row(ppd_pkg::REG_DOWN_FACTOR, 3));
		plan.push_back(reg_row(ppd_pkg::REG_NEURAL_COUNT, 8));
		plan.push_back(reg_row(ppd_pkg::REG_MIX_LOW_BAND, 1));
		plan.push_back(item_row(0, 32767, 1, 1, 1, 1, -32768));
		plan.push_back(item_row(0, -32768, -1, 1, 1, 1, 32767));
		plan.push_back(item_row(4, 9, 100, 0, 1, 1, 9));
		// oversized factor clamps
		plan.push_back(reg_row(ppd_pkg::REG_DOWN_FACTOR, 8191));
		plan.push_back(item_row(2, -32768, 0, 0));
		plan.push_back(item_row(2, 32767, 0, 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].wdata);
			end else begin
				send_item(plan[i]);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin fac = 2; spk = 4; neu = 8; mix = 1; end
				1: begin fac = 4096; spk = 512; neu = 0; mix = 0; end
				2: begin fac = 8191; spk = 1023; neu = 1023; mix = 1; end
				3: begin fac = 0; spk = 3; neu = 6; mix = 1; end
				default: begin
					fac = $urandom_range(1, 6);
					spk = $urandom_range(0, 8);
					neu = $urandom_range(1) ? 2 * spk : $urandom_range(0, 1023);
					mix = $urandom_range(1);
				end
			endcase
			settle();
			write_reg(ppd_pkg::REG_DOWN_FACTOR, fac);
			write_reg(ppd_pkg::REG_SPIKE_COUNT, spk);
			write_reg(ppd_pkg::REG_NEURAL_COUNT, neu);
			write_reg(ppd_pkg::REG_MIX_LOW_BAND, mix);
			// idle pattern rotates across phases
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 69; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 69; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			repeat (ITEMS_PER_PHASE) send_item(random_item());
		end

		settle();
		if (fail_count == 0)
			$display("peak_preserving_decimator_test passed");
		else
			$display("peak_preserving_decimator_test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/ppd_pkg.sv
src/ppd_front.sv
src/ppd_back.sv
src/ppd_result_queue.sv
src/peak_preserving_decimator.sv
bench/peak_preserving_decimator_test.sv
